[src/assert_macros.svh]
// Assertion helpers included by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication or expression on every clock edge outside reset.
`define ASSERT_CHECK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Checks that a condition is followed by a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) \
    else $error("assertion failed");

`endif

[src/vca_pkg.sv]
`default_nettype none

package vca_pkg;

  // Field widths of the stream payloads.
  localparam int SOUND_W     = 8;
  localparam int CHAN_W      = 4;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  // Opcodes carried on in_tuser.
  localparam logic OP_PLAY = 1'b0;
  localparam logic OP_STOP = 1'b1;

  // Sound id that marks an empty request.
  localparam logic [SOUND_W-1:0] INVALID_ID = 8'hFF;

  // Result status codes.
  localparam logic [1:0] STATUS_PLAYED  = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_STOPPED = 2'd2;

  // How the channel was chosen.
  localparam logic [1:0] KIND_REUSED = 2'd0;
  localparam logic [1:0] KIND_IDLE   = 2'd1;
  localparam logic [1:0] KIND_STOLEN = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  // Per-channel status flags kept next to the sound id and age.
  typedef struct packed {
    logic bound;
    logic playing;
  } vca_flags_t;

endpackage

`default_nettype wire

[src/vca_chan_mem.sv]
`default_nettype none

module vca_chan_mem #(
  parameter int NUM_CHANNELS = 16,
  parameter int AGE_WIDTH    = 16,
  parameter int IDX_W        = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          rd_en,
  input  wire logic [IDX_W-1:0]              rd_addr,
  output logic [vca_pkg::SOUND_W-1:0]        rd_sound,
  output vca_pkg::vca_flags_t                rd_flags,
  output logic [AGE_WIDTH-1:0]               rd_age,
  input  wire logic                          wr_en,
  input  wire logic [IDX_W-1:0]              wr_addr,
  input  wire logic [vca_pkg::SOUND_W-1:0]   wr_sound,
  input  wire vca_pkg::vca_flags_t           wr_flags,
  input  wire logic [AGE_WIDTH-1:0]          wr_age
);
  import vca_pkg::*;

  localparam int ENTRY_W = SOUND_W + 2 + AGE_WIDTH;
  localparam logic [AGE_WIDTH-1:0] AGE_RESET = AGE_WIDTH'(NUM_CHANNELS);

  logic [ENTRY_W-1:0]      mem_r [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld_r;
  logic [ENTRY_W-1:0]      rd_data_r;
  logic                    rd_vld_r;

  // Entry storage: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= {wr_sound, wr_flags, wr_age};
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // Valid bits stand in for a clearing pass after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // An entry never written reads as the reset state of a channel.
  always_comb begin
    if (rd_vld_r) begin
      rd_sound = rd_data_r[ENTRY_W-1 -: SOUND_W];
      rd_flags = rd_data_r[AGE_WIDTH +: 2];
      rd_age   = rd_data_r[AGE_WIDTH-1:0];
    end else begin
      rd_sound = '0;
      rd_flags = '0;
      rd_age   = AGE_RESET;
    end
  end

endmodule

`default_nettype wire

[src/voice_channel_allocator_lru.sv]
// Flow: a play passes through ST_SCAN, ST_DRAIN, ST_COMMIT and ST_DONE before out_tvalid,
// a stop through ST_STOP and ST_DONE, and a play with the invalid id through ST_DONE alone.
// A new request is taken only in ST_IDLE, once the last result has entered the output
// register; the scan reads every channel entry once through the single read port.
// Reset: synchronous on rst_n; all channels become unbound, idle and aged
// NUM_CHANNELS at once through per-entry valid bits, with no clearing pass.
`default_nettype none

module voice_channel_allocator_lru #(
  parameter int NUM_CHANNELS = 16,
  parameter int AGE_WIDTH    = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // in_tdata: sound_id[7:0], reuse_existing[8], stop_channel[12:9], zero fill
  input  wire logic [vca_pkg::IN_TDATA_W-1:0]    in_tdata,
  // in_tuser: opcode[0]
  input  wire logic [0:0]                        in_tuser,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // out_tdata: channel[3:0], choice_kind[5:4], preempted[6], zero fill
  output logic [vca_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // out_tuser: status[1:0]
  output logic [1:0]                             out_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready
);
  import vca_pkg::*;
  `include "assert_macros.svh"

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CNT_W = $clog2(NUM_CHANNELS + 1);
  localparam logic [CNT_W-1:0]     LAST_CNT = CNT_W'(NUM_CHANNELS - 1);
  localparam logic [AGE_WIDTH-1:0] AGE_MAX  = {AGE_WIDTH{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_STOP,
    ST_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [SOUND_W-1:0]   sid_r, sid_nxt;
  logic                 reuse_r, reuse_nxt;
  logic [CHAN_W-1:0]    stop_r, stop_nxt;
  logic [CNT_W-1:0]     rd_cnt_r, rd_cnt_nxt;
  logic                 p_v_r, p_v_nxt;
  logic [IDX_W-1:0]     p_idx_r, p_idx_nxt;
  logic                 bm_found_r, bm_found_nxt;
  logic [IDX_W-1:0]     bm_idx_r, bm_idx_nxt;
  logic                 bm_play_r, bm_play_nxt;
  logic                 idle_found_r, idle_found_nxt;
  logic [IDX_W-1:0]     idle_idx_r, idle_idx_nxt;
  logic [IDX_W-1:0]     max_idx_r, max_idx_nxt;
  logic [AGE_WIDTH-1:0] max_age_r, max_age_nxt;
  logic [1:0]           res_status_r, res_status_nxt;
  logic [CHAN_W-1:0]    res_chan_r, res_chan_nxt;
  logic [1:0]           res_kind_r, res_kind_nxt;
  logic                 res_pre_r, res_pre_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [CHAN_W-1:0]    out_chan_r, out_chan_nxt;
  logic [1:0]           out_kind_r, out_kind_nxt;
  logic                 out_pre_r, out_pre_nxt;

  logic                 mem_rd_en;
  logic [IDX_W-1:0]     mem_rd_addr;
  logic [SOUND_W-1:0]   mem_rd_sound;
  vca_flags_t           mem_rd_flags;
  logic [AGE_WIDTH-1:0] mem_rd_age;
  logic                 mem_wr_en;
  logic [IDX_W-1:0]     mem_wr_addr;
  logic [SOUND_W-1:0]   mem_wr_sound;
  vca_flags_t           mem_wr_flags;
  logic [AGE_WIDTH-1:0] mem_wr_age;

  logic                 in_fire;
  logic [AGE_WIDTH-1:0] age_inc;
  logic [IDX_W-1:0]     pick;

  vca_chan_mem #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .AGE_WIDTH    (AGE_WIDTH),
    .IDX_W        (IDX_W)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (mem_rd_en),
    .rd_addr  (mem_rd_addr),
    .rd_sound (mem_rd_sound),
    .rd_flags (mem_rd_flags),
    .rd_age   (mem_rd_age),
    .wr_en    (mem_wr_en),
    .wr_addr  (mem_wr_addr),
    .wr_sound (mem_wr_sound),
    .wr_flags (mem_wr_flags),
    .wr_age   (mem_wr_age)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_pre_r, out_kind_r, out_chan_r};
  assign out_tuser  = out_status_r;

  // Saturating age step for the entry coming back from memory.
  assign age_inc = (mem_rd_age == AGE_MAX) ? mem_rd_age : mem_rd_age + AGE_WIDTH'(1);

  always_comb begin
    state_nxt      = state_r;
    sid_nxt        = sid_r;
    reuse_nxt      = reuse_r;
    stop_nxt       = stop_r;
    rd_cnt_nxt     = rd_cnt_r;
    p_v_nxt        = 1'b0;
    p_idx_nxt      = p_idx_r;
    bm_found_nxt   = bm_found_r;
    bm_idx_nxt     = bm_idx_r;
    bm_play_nxt    = bm_play_r;
    idle_found_nxt = idle_found_r;
    idle_idx_nxt   = idle_idx_r;
    max_idx_nxt    = max_idx_r;
    max_age_nxt    = max_age_r;
    res_status_nxt = res_status_r;
    res_chan_nxt   = res_chan_r;
    res_kind_nxt   = res_kind_r;
    res_pre_nxt    = res_pre_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_chan_nxt   = out_chan_r;
    out_kind_nxt   = out_kind_r;
    out_pre_nxt    = out_pre_r;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = '0;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = p_idx_r;
    mem_wr_sound   = mem_rd_sound;
    mem_wr_flags   = mem_rd_flags;
    mem_wr_age     = age_inc;
    pick           = max_idx_r;

    // Scan data: age the entry in place and track the three candidates.
    if (p_v_r) begin
      mem_wr_en = 1'b1;
      if (reuse_r && !bm_found_r && mem_rd_flags.bound && (mem_rd_sound == sid_r)) begin
        bm_found_nxt = 1'b1;
        bm_idx_nxt   = p_idx_r;
        bm_play_nxt  = mem_rd_flags.playing;
      end
      if (!idle_found_r && !mem_rd_flags.playing) begin
        idle_found_nxt = 1'b1;
        idle_idx_nxt   = p_idx_r;
      end
      if ((p_idx_r == '0) || (mem_rd_age > max_age_r)) begin
        max_idx_nxt = p_idx_r;
        max_age_nxt = mem_rd_age;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          sid_nxt        = in_tdata[7:0];
          reuse_nxt      = in_tdata[8];
          stop_nxt       = in_tdata[12:9];
          bm_found_nxt   = 1'b0;
          idle_found_nxt = 1'b0;
          rd_cnt_nxt     = '0;
          if (in_tuser[0] == OP_STOP) begin
            mem_rd_en   = (int'(in_tdata[12:9]) < NUM_CHANNELS);
            mem_rd_addr = IDX_W'(in_tdata[12:9]);
            state_nxt   = ST_STOP;
          end else if (in_tdata[7:0] == INVALID_ID) begin
            res_status_nxt = STATUS_INVALID;
            res_chan_nxt   = '0;
            res_kind_nxt   = KIND_NONE;
            res_pre_nxt    = 1'b0;
            state_nxt      = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      // Issue one read per cycle; write-back trails one address behind.
      ST_SCAN: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = rd_cnt_r[IDX_W-1:0];
        p_v_nxt     = 1'b1;
        p_idx_nxt   = rd_cnt_r[IDX_W-1:0];
        rd_cnt_nxt  = rd_cnt_r + CNT_W'(1);
        if (rd_cnt_r == LAST_CNT) begin
          state_nxt = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        state_nxt = ST_COMMIT;
      end

      // Bind the chosen channel; it ends at age one after the global step.
      ST_COMMIT: begin
        if (bm_found_r) begin
          pick         = bm_idx_r;
          res_kind_nxt = KIND_REUSED;
          res_pre_nxt  = bm_play_r;
        end else if (idle_found_r) begin
          pick         = idle_idx_r;
          res_kind_nxt = KIND_IDLE;
          res_pre_nxt  = 1'b0;
        end else begin
          pick         = max_idx_r;
          res_kind_nxt = KIND_STOLEN;
          res_pre_nxt  = 1'b1;
        end
        mem_wr_en            = 1'b1;
        mem_wr_addr          = pick;
        mem_wr_sound         = sid_r;
        mem_wr_flags.bound   = 1'b1;
        mem_wr_flags.playing = 1'b1;
        mem_wr_age           = AGE_WIDTH'(1);
        res_status_nxt       = STATUS_PLAYED;
        res_chan_nxt         = CHAN_W'(pick);
        state_nxt            = ST_DONE;
      end

      // Clear the playing flag and keep the binding and age.
      ST_STOP: begin
        mem_wr_en            = (int'(stop_r) < NUM_CHANNELS);
        mem_wr_addr          = IDX_W'(stop_r);
        mem_wr_age           = mem_rd_age;
        mem_wr_flags.playing = 1'b0;
        res_status_nxt       = STATUS_STOPPED;
        res_chan_nxt         = stop_r;
        res_kind_nxt         = KIND_NONE;
        res_pre_nxt          = 1'b0;
        state_nxt            = ST_DONE;
      end

      // Hand the result to the output register once it is free.
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_chan_nxt   = res_chan_r;
          out_kind_nxt   = res_kind_r;
          out_pre_nxt    = res_pre_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, control and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      p_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      p_v_r       <= p_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sid_r        <= sid_nxt;
    reuse_r      <= reuse_nxt;
    stop_r       <= stop_nxt;
    rd_cnt_r     <= rd_cnt_nxt;
    p_idx_r      <= p_idx_nxt;
    bm_found_r   <= bm_found_nxt;
    bm_idx_r     <= bm_idx_nxt;
    bm_play_r    <= bm_play_nxt;
    idle_found_r <= idle_found_nxt;
    idle_idx_r   <= idle_idx_nxt;
    max_idx_r    <= max_idx_nxt;
    max_age_r    <= max_age_nxt;
    res_status_r <= res_status_nxt;
    res_chan_r   <= res_chan_nxt;
    res_kind_r   <= res_kind_nxt;
    res_pre_r    <= res_pre_nxt;
    out_status_r <= out_status_nxt;
    out_chan_r   <= out_chan_nxt;
    out_kind_r   <= out_kind_nxt;
    out_pre_r    <= out_pre_nxt;
  end

  // The read-modify-write scan never reads the entry it writes in the same cycle.
  `ASSERT_CHECK(a_no_rw_overlap, clk, rst_n,
    (mem_rd_en && mem_wr_en) |-> (mem_rd_addr != mem_wr_addr))
  // A steal, which only happens when every channel is playing, is reported as a preemption.
  `ASSERT_CHECK(a_steal_preempts, clk, rst_n,
    (out_valid_r && (out_kind_r == KIND_STOLEN)) |-> out_pre_r)
  // Results other than a play carry no choice and no preemption.
  `ASSERT_CHECK(a_nonplay_fields, clk, rst_n,
    (out_valid_r && (out_status_r != STATUS_PLAYED)) |-> ((out_kind_r == KIND_NONE) && !out_pre_r))
  // Every accepted transaction leaves the idle state.
  `ASSERT_NEXT(a_accept_busy, clk, rst_n, in_fire, (state_r != ST_IDLE))

endmodule

`default_nettype wire
